### src/cdq_pkg.sv
package cdq_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int PTR_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int CAP_W      = 7;
  localparam int FIELD_W    = 32;

  typedef logic [PTR_W-1:0]      ptr_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [CAP_W-1:0]      cap_t;
  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [FIELD_W-1:0]    field_t;

  localparam cap_t CAP_RESET    = 7'd64;
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [2:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_LIST       = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_REFUSE_FULL,
    OP_REFUSE_EMPTY,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_LIST_START,
    OP_DELIVER
  } op_t;

  typedef struct packed {
    logic capture;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       empty;
    logic       full;
    logic       rem_one;
    logic       out_free;
  } sts_t;

  // A capacity of zero behaves as one, and anything above the store depth as the depth.
  function automatic cnt_t eff_cap(cap_t cap);
    if (cap == '0) begin
      return cnt_t'(1);
    end
    if (int'(cap) > DEPTH) begin
      return cnt_t'(DEPTH);
    end
    return cnt_t'(cap);
  endfunction

  function automatic ptr_t step_up(ptr_t p, cnt_t c);
    cnt_t nxt;
    nxt = cnt_t'(p) + cnt_t'(1);
    return (nxt >= c) ? '0 : ptr_t'(nxt);
  endfunction

  function automatic ptr_t step_down(ptr_t p, cnt_t c);
    if (p == '0 || cnt_t'(p) >= c) begin
      return ptr_t'(c - cnt_t'(1));
    end
    return p - ptr_t'(1);
  endfunction

endpackage

### src/cdq_ram.sv
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/cdq_ctrl.sv
module cdq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  cdq_pkg::sts_t  sts,
  output logic           req_stall,
  output cdq_pkg::cmd_t  cmd
);

  cdq_pkg::state_t state;
  cdq_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cdq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      cdq_pkg::ST_IDLE: begin
        if (req_valid) begin
          state_next = cdq_pkg::ST_EXEC;
        end
      end
      cdq_pkg::ST_EXEC: begin
        unique case (sts.kind)
          cdq_pkg::KIND_PUSH_FRONT, cdq_pkg::KIND_PUSH_BACK: begin
            if (sts.out_free) begin
              state_next = cdq_pkg::ST_IDLE;
            end
          end
          cdq_pkg::KIND_POP_FRONT, cdq_pkg::KIND_POP_BACK, cdq_pkg::KIND_LIST: begin
            if (sts.out_free) begin
              state_next = sts.empty ? cdq_pkg::ST_IDLE : cdq_pkg::ST_READ;
            end
          end
          default: begin
            state_next = cdq_pkg::ST_IDLE;
          end
        endcase
      end
      cdq_pkg::ST_READ: begin
        if (sts.out_free && sts.rem_one) begin
          state_next = cdq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cdq_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    req_stall   = 1'b1;
    cmd.capture = 1'b0;
    cmd.op      = cdq_pkg::OP_NONE;
    unique case (state)
      cdq_pkg::ST_IDLE: begin
        req_stall   = 1'b0;
        cmd.capture = req_valid;
      end
      cdq_pkg::ST_EXEC: begin
        if (sts.out_free) begin
          unique case (sts.kind)
            cdq_pkg::KIND_PUSH_FRONT: begin
              cmd.op = sts.full ? cdq_pkg::OP_REFUSE_FULL : cdq_pkg::OP_PUSH_FRONT;
            end
            cdq_pkg::KIND_PUSH_BACK: begin
              cmd.op = sts.full ? cdq_pkg::OP_REFUSE_FULL : cdq_pkg::OP_PUSH_BACK;
            end
            cdq_pkg::KIND_POP_FRONT: begin
              cmd.op = sts.empty ? cdq_pkg::OP_REFUSE_EMPTY : cdq_pkg::OP_POP_FRONT;
            end
            cdq_pkg::KIND_POP_BACK: begin
              cmd.op = sts.empty ? cdq_pkg::OP_REFUSE_EMPTY : cdq_pkg::OP_POP_BACK;
            end
            cdq_pkg::KIND_LIST: begin
              cmd.op = sts.empty ? cdq_pkg::OP_REFUSE_EMPTY : cdq_pkg::OP_LIST_START;
            end
            default: begin
              cmd.op = cdq_pkg::OP_NONE;
            end
          endcase
        end
      end
      cdq_pkg::ST_READ: begin
        if (sts.out_free) begin
          cmd.op = cdq_pkg::OP_DELIVER;
        end
      end
      default: begin
        cmd.op = cdq_pkg::OP_NONE;
      end
    endcase
  end

endmodule

### src/cdq_dp.sv
module cdq_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  input  logic [2:0]          kind,
  input  logic signed [31:0]  value,
  input  logic                rsp_stall,
  input  cdq_pkg::cmd_t       cmd,
  output cdq_pkg::sts_t       sts,
  output logic                rsp_valid,
  output logic [1:0]          status,
  output logic signed [31:0]  data,
  output logic                last
);

  cdq_pkg::cap_t  capacity;
  cdq_pkg::ptr_t  front_ptr;
  cdq_pkg::ptr_t  front_next;
  cdq_pkg::ptr_t  rear_ptr;
  cdq_pkg::ptr_t  rear_next;
  cdq_pkg::cnt_t  occupancy;
  cdq_pkg::cnt_t  occupancy_next;
  cdq_pkg::ptr_t  walk_ptr;
  cdq_pkg::ptr_t  walk_next;
  cdq_pkg::cnt_t  remaining;
  cdq_pkg::cnt_t  remaining_next;
  logic [2:0]     kind_q;
  logic [31:0]    value_q;
  cdq_pkg::cnt_t  eff;
  logic           cfg_write;
  logic           rem_one;

  logic            we;
  cdq_pkg::ptr_t   waddr;
  logic            re;
  cdq_pkg::ptr_t   raddr;
  cdq_pkg::word_t  rdata;

  logic              load;
  cdq_pkg::status_t  load_status;
  cdq_pkg::field_t   load_data;
  logic              load_last;

  assign cfg_write = psel && penable && pwrite && (paddr[2] == cdq_pkg::REG_CAPACITY);
  assign prdata    = (paddr[2] == cdq_pkg::REG_CAPACITY) ? cdq_pkg::field_t'(capacity) : '0;
  assign eff       = cdq_pkg::eff_cap(capacity);
  assign rem_one   = (remaining == cdq_pkg::cnt_t'(1));

  assign sts.kind     = kind_q;
  assign sts.empty    = (occupancy == '0);
  assign sts.full     = (occupancy >= eff);
  assign sts.rem_one  = rem_one;
  assign sts.out_free = !rsp_valid || !rsp_stall;

  always_comb begin
    we             = 1'b0;
    waddr          = front_ptr;
    re             = 1'b0;
    raddr          = front_ptr;
    front_next     = front_ptr;
    rear_next      = rear_ptr;
    occupancy_next = occupancy;
    walk_next      = walk_ptr;
    remaining_next = remaining;
    load           = 1'b0;
    load_status    = cdq_pkg::STS_OK;
    load_data      = '0;
    load_last      = 1'b1;
    unique case (cmd.op)
      cdq_pkg::OP_PUSH_FRONT, cdq_pkg::OP_PUSH_BACK: begin
        we             = 1'b1;
        load           = 1'b1;
        occupancy_next = occupancy + cdq_pkg::cnt_t'(1);
        if (occupancy == '0) begin
          // An empty deque restarts both pointers at the first slot.
          front_next = '0;
          rear_next  = '0;
          waddr      = '0;
        end else if (cmd.op == cdq_pkg::OP_PUSH_FRONT) begin
          front_next = cdq_pkg::step_down(front_ptr, eff);
          waddr      = front_next;
        end else begin
          rear_next = cdq_pkg::step_up(rear_ptr, eff);
          waddr     = rear_next;
        end
      end
      cdq_pkg::OP_REFUSE_FULL: begin
        load        = 1'b1;
        load_status = cdq_pkg::STS_FULL;
      end
      cdq_pkg::OP_REFUSE_EMPTY: begin
        load        = 1'b1;
        load_status = cdq_pkg::STS_EMPTY;
      end
      cdq_pkg::OP_POP_FRONT: begin
        re             = 1'b1;
        raddr          = front_ptr;
        front_next     = cdq_pkg::step_up(front_ptr, eff);
        occupancy_next = occupancy - cdq_pkg::cnt_t'(1);
        remaining_next = cdq_pkg::cnt_t'(1);
      end
      cdq_pkg::OP_POP_BACK: begin
        re             = 1'b1;
        raddr          = rear_ptr;
        rear_next      = cdq_pkg::step_down(rear_ptr, eff);
        occupancy_next = occupancy - cdq_pkg::cnt_t'(1);
        remaining_next = cdq_pkg::cnt_t'(1);
      end
      cdq_pkg::OP_LIST_START: begin
        re             = 1'b1;
        raddr          = front_ptr;
        walk_next      = cdq_pkg::step_up(front_ptr, eff);
        remaining_next = occupancy;
      end
      cdq_pkg::OP_DELIVER: begin
        load      = 1'b1;
        load_data = cdq_pkg::field_t'(rdata);
        load_last = rem_one;
        if (!rem_one) begin
          re             = 1'b1;
          raddr          = walk_ptr;
          walk_next      = cdq_pkg::step_up(walk_ptr, eff);
          remaining_next = remaining - cdq_pkg::cnt_t'(1);
        end
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= cdq_pkg::CAP_RESET;
      front_ptr <= '0;
      rear_ptr  <= '0;
      occupancy <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        capacity  <= cdq_pkg::cap_t'(pwdata[cdq_pkg::CAP_W-1:0]);
        front_ptr <= '0;
        rear_ptr  <= '0;
        occupancy <= '0;
      end else begin
        front_ptr <= front_next;
        rear_ptr  <= rear_next;
        occupancy <= occupancy_next;
      end
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_q  <= kind;
      value_q <= value;
    end
    walk_ptr  <= walk_next;
    remaining <= remaining_next;
    if (load) begin
      status <= load_status;
      data   <= load_data;
      last   <= load_last;
    end
  end

  cdq_ram #(
    .WIDTH(cdq_pkg::DATA_WIDTH),
    .DEPTH(cdq_pkg::DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(cdq_pkg::word_t'(value_q)),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

endmodule

### src/circular_deque.sv
// Double-ended queue held in a circular store of 64 words, limited to a
// programmable capacity. Requests arrive on the req channel (kind, value)
// and results leave on the rsp channel (status, data, last); both use
// valid and stall, and a beat moves when valid is high and stall is low.
// A push or a refused request gives one result beat, which the execute
// state loads into the result register. A pop reads the store in the
// execute state and delivers the word from the read state, since the
// store has a registered read port. A listing reads its first entry in
// the execute state and then gives one entry per cycle from front to rear
// while the receiver does not stall, marking the final one with last; an
// empty deque gives one beat with the empty status. The store has a single
// read port. Unused kinds are dropped without a result.
// Reset clears the pointers and the count and sets the capacity to 64; the
// store itself is not cleared, as only written words are ever read.
// When the receiver stalls, the result register holds its beat and the
// block waits; one further request is still taken and kept until the
// result register frees. Writing the capacity register empties the deque.
module circular_deque (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [2:0]         kind,
  input  logic signed [31:0] value,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic [1:0]         status,
  output logic signed [31:0] data,
  output logic               last
);

  cdq_pkg::cmd_t cmd;
  cdq_pkg::sts_t sts;

  // Register accesses complete in their access cycle.
  assign pready = 1'b1;

  cdq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .sts      (sts),
    .req_stall(req_stall),
    .cmd      (cmd)
  );

  cdq_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .kind     (kind),
    .value    (value),
    .rsp_stall(rsp_stall),
    .cmd      (cmd),
    .sts      (sts),
    .rsp_valid(rsp_valid),
    .status   (status),
    .data     (data),
    .last     (last)
  );

endmodule

### src/cdq_checker.sv
module cdq_checker (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_stall,
  input logic               rsp_valid,
  input logic               rsp_stall,
  input logic [1:0]         status,
  input logic signed [31:0] data,
  input logic               last
);

  // Nothing is offered on the result side straight after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result beat offered after reset");

  // A stalled result beat holds its payload.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(data) && $stable(last))
    else $error("stalled result beat changed");

  // Requests are handled one at a time: a taken beat closes the request side.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("second request taken while one is in progress");

  // A fresh result only appears while a request is being worked on.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall))
    else $error("result beat without a request in progress");

  // Refusals carry zero data and close their request.
  a_refusal: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != 2'd0 |-> last && data == 32'sd0)
    else $error("refusal beat with data or without last");

endmodule

bind circular_deque cdq_checker u_cdq_checker (.*);

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  // Kinds 5 to 7 are not operations. The block must swallow them without
  // a result.
  localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
  localparam logic [2:0] KIND_UNUSED_HI = 3'd7;
  localparam logic [2:0] CAPACITY_ADDR  = 3'(4 * int'(cdq_pkg::REG_CAPACITY));

  // The settle wait after the last result lets a dropped kind that is still
  // in flight finish before a register write.
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 16;
  localparam int QUIET_LIMIT   = 2000;
  localparam int HOLD_OFF_LEN  = 150;

  typedef struct {
    cdq_pkg::status_t status;
    cdq_pkg::word_t   data;
    logic             last;
  } result_t;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [2:0]         paddr     = '0;
  logic [31:0]        pwdata    = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               req_valid = 1'b0;
  logic               req_stall;
  logic [2:0]         kind      = '0;
  logic signed [31:0] value     = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  logic [1:0]         status;
  logic signed [31:0] data;
  logic               last;

  // The bench's own picture of the deque.
  cdq_pkg::word_t shadow_store [cdq_pkg::DEPTH];
  cdq_pkg::ptr_t  head_ptr = '0;
  cdq_pkg::ptr_t  tail_ptr = '0;
  int             fill     = 0;
  cdq_pkg::cap_t  cap_reg  = cdq_pkg::CAP_RESET;
  result_t        pending_results [$];

  int mismatches      = 0;
  bit sender_idles    = 1'b1;
  bit receiver_idles  = 1'b1;
  int hold_off_cycles = 0;

  circular_deque u_dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .kind      (kind),
    .value     (value),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .data      (data),
    .last      (last)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Behavioural deque
  // ---------------------------------------------------------------------

  // A programmed capacity of zero holds one entry. Anything above the store
  // depth is clipped to the depth.
  function automatic int usable_capacity();
    if (cap_reg == '0) begin
      return 1;
    end
    if (int'(cap_reg) > cdq_pkg::DEPTH) begin
      return cdq_pkg::DEPTH;
    end
    return int'(cap_reg);
  endfunction

  function automatic cdq_pkg::ptr_t ring_next(cdq_pkg::ptr_t p);
    if (int'(p) + 1 >= usable_capacity()) begin
      return '0;
    end
    return p + cdq_pkg::ptr_t'(1);
  endfunction

  // Stepping back from slot zero, or from a slot beyond the current
  // capacity, lands on the top slot of the ring.
  function automatic cdq_pkg::ptr_t ring_prev(cdq_pkg::ptr_t p);
    if (p == '0 || int'(p) >= usable_capacity()) begin
      return cdq_pkg::ptr_t'(usable_capacity() - 1);
    end
    return p - cdq_pkg::ptr_t'(1);
  endfunction

  function automatic void expect_result(cdq_pkg::status_t s, cdq_pkg::word_t d, logic l);
    result_t r;
    r.status = s;
    r.data   = d;
    r.last   = l;
    pending_results.push_back(r);
  endfunction

  // Applies one accepted request to the shadow deque and queues the result
  // beats it must produce.
  function automatic void predict_deque_results(logic [2:0] op, cdq_pkg::word_t word);
    cdq_pkg::ptr_t p;
    case (op)
      cdq_pkg::KIND_PUSH_FRONT, cdq_pkg::KIND_PUSH_BACK: begin
        if (fill >= usable_capacity()) begin
          expect_result(cdq_pkg::STS_FULL, '0, 1'b1);
        end else begin
          // The first entry of an empty deque always goes to slot zero.
          if (fill == 0) begin
            head_ptr        = '0;
            tail_ptr        = '0;
            shadow_store[0] = word;
          end else if (op == cdq_pkg::KIND_PUSH_FRONT) begin
            head_ptr               = ring_prev(head_ptr);
            shadow_store[head_ptr] = word;
          end else begin
            tail_ptr               = ring_next(tail_ptr);
            shadow_store[tail_ptr] = word;
          end
          fill++;
          expect_result(cdq_pkg::STS_OK, '0, 1'b1);
        end
      end
      cdq_pkg::KIND_POP_FRONT, cdq_pkg::KIND_POP_BACK: begin
        if (fill == 0) begin
          expect_result(cdq_pkg::STS_EMPTY, '0, 1'b1);
        end else if (op == cdq_pkg::KIND_POP_FRONT) begin
          expect_result(cdq_pkg::STS_OK, shadow_store[head_ptr], 1'b1);
          head_ptr = ring_next(head_ptr);
          fill--;
        end else begin
          expect_result(cdq_pkg::STS_OK, shadow_store[tail_ptr], 1'b1);
          tail_ptr = ring_prev(tail_ptr);
          fill--;
        end
      end
      cdq_pkg::KIND_LIST: begin
        if (fill == 0) begin
          expect_result(cdq_pkg::STS_EMPTY, '0, 1'b1);
        end else begin
          p = head_ptr;
          for (int i = 0; i < fill; i++) begin
            expect_result(cdq_pkg::STS_OK, shadow_store[p], logic'(i == fill - 1));
            p = ring_next(p);
          end
        end
      end
      default: begin
        // Unused kinds leave everything as it was.
      end
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------
  // Monitor: a request beat feeds the shadow deque, and a result beat is
  // checked against the oldest expectation. Both are sampled at the
  // rising edge, before the block's own registers update.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (!rst && req_valid === 1'b1 && req_stall === 1'b0) begin
      predict_deque_results(kind, cdq_pkg::word_t'(value));
    end
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing expected (status %0d data %h)",
                                  status, data));
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) begin
          report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
        end
        if (data !== want.data) begin
          report_mismatch($sformatf("data %h, expected %h", data, want.data));
        end
        if (last !== want.last) begin
          report_mismatch($sformatf("last %b, expected %b", last, want.last));
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: before each result beat it stalls for a random number of
  // cycles, unless idling is switched off. It may also be told to hold off
  // for a long run, which it counts out here by itself.
  // ---------------------------------------------------------------------
  initial begin
    int gap;
    forever begin
      if (hold_off_cycles > 0) begin
        repeat (hold_off_cycles) begin
          @(negedge clk);
          rsp_stall <= 1'b1;
        end
        hold_off_cycles = 0;
      end
      gap = receiver_idles ? $urandom_range(0, 7) : 0;
      repeat (gap) begin
        @(negedge clk);
        rsp_stall <= 1'b1;
      end
      @(negedge clk);
      rsp_stall <= 1'b0;
      do @(posedge clk); while (rsp_valid !== 1'b1);
    end
  end

  // Watchdog: the run is given up if no beat moves on either channel for
  // too long. The long hold-off is far shorter than this limit.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t ns: no beat has moved for %0d cycles", $time, QUIET_LIMIT);
    $display("circular_deque regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Shared drivers
  // ---------------------------------------------------------------------

  // Offers one request beat after an optional idle gap, then waits for the
  // block to take it. Valid stays high afterwards, so a zero gap on the
  // next call gives back-to-back beats.
  task automatic send_request(logic [2:0] op, logic [31:0] word);
    int gap;
    gap = sender_idles ? $urandom_range(0, 7) : 0;
    @(negedge clk);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    kind      <= op;
    value     <= word;
    do @(posedge clk); while (req_stall !== 1'b0);
  endtask

  // The sender stops and waits until every expected beat has arrived. It
  // then allows a few more cycles for any dropped kind still in flight.
  task automatic wait_for_results();
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writing the capacity register also empties the deque, so the shadow
  // copy is cleared with it.
  task automatic write_capacity(cdq_pkg::cap_t cap);
    wait_for_results();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAPACITY_ADDR;
    pwdata  <= 32'(cap);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    cap_reg  = cap;
    head_ptr = '0;
    tail_ptr = '0;
    fill     = 0;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [2:0] any_push();
    return $urandom_range(0, 1) ? cdq_pkg::KIND_PUSH_BACK : cdq_pkg::KIND_PUSH_FRONT;
  endfunction

  function automatic logic [2:0] any_pop();
    return $urandom_range(0, 1) ? cdq_pkg::KIND_POP_BACK : cdq_pkg::KIND_POP_FRONT;
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // At the reset capacity, this covers the empty refusals, the extreme
  // data words, pushes and pops at both ends, listings and the unused kinds.
  task automatic test_basic_operations();
    send_request(cdq_pkg::KIND_LIST, 32'h1234_5678);
    send_request(cdq_pkg::KIND_POP_FRONT, '0);
    send_request(cdq_pkg::KIND_POP_BACK, '1);
    send_request(cdq_pkg::KIND_PUSH_BACK, 32'h7FFF_FFFF);
    send_request(cdq_pkg::KIND_PUSH_FRONT, 32'h8000_0000);
    send_request(cdq_pkg::KIND_PUSH_BACK, 32'h0000_0000);
    send_request(cdq_pkg::KIND_PUSH_FRONT, 32'hFFFF_FFFF);
    send_request(cdq_pkg::KIND_LIST, '0);
    for (int k = int'(KIND_UNUSED_LO); k <= int'(KIND_UNUSED_HI); k++) begin
      send_request(3'(k), $urandom);
    end
    send_request(cdq_pkg::KIND_POP_FRONT, '0);
    send_request(cdq_pkg::KIND_POP_BACK, '0);
    send_request(cdq_pkg::KIND_LIST, '0);
    send_request(cdq_pkg::KIND_POP_FRONT, '0);
    send_request(cdq_pkg::KIND_POP_BACK, '0);
    send_request(cdq_pkg::KIND_POP_FRONT, '0);
  endtask

  // A capacity of zero behaves as one. A capacity of two makes push-front
  // wrap from slot zero to the top slot and refuses the third push.
  task automatic test_capacity_edges();
    write_capacity('0);
    send_request(cdq_pkg::KIND_PUSH_BACK, 32'hA5A5_5A5A);
    send_request(cdq_pkg::KIND_PUSH_FRONT, 32'h0F0F_F0F0);
    send_request(cdq_pkg::KIND_LIST, '0);
    send_request(cdq_pkg::KIND_POP_BACK, '0);
    send_request(cdq_pkg::KIND_POP_FRONT, '0);
    write_capacity(cdq_pkg::cap_t'(2));
    send_request(cdq_pkg::KIND_PUSH_FRONT, $urandom);
    send_request(cdq_pkg::KIND_PUSH_FRONT, $urandom);
    send_request(cdq_pkg::KIND_PUSH_BACK, $urandom);
    // Rewriting the capacity with data held must drop it: the listing
    // afterwards comes back empty.
    write_capacity(cdq_pkg::cap_t'(2));
    send_request(cdq_pkg::KIND_LIST, '0);
  endtask

  // The receiver holds off for a long run while the sender keeps offering
  // beats back to back. The block fills its result path and must stall
  // the request channel without losing anything. After that the sender
  // waits for every expected result beat to arrive.
  task automatic test_result_backpressure();
    write_capacity(cdq_pkg::CAP_RESET);
    sender_idles    = 1'b0;
    hold_off_cycles = HOLD_OFF_LEN;
    for (int i = 0; i < 8; i++) begin
      send_request(cdq_pkg::KIND_PUSH_BACK, $urandom);
    end
    send_request(cdq_pkg::KIND_LIST, '0);
    for (int i = 0; i < 4; i++) begin
      send_request(any_pop(), '0);
    end
    wait_for_results();
    sender_idles = 1'b1;
  endtask

  // Fills the whole store with random words from random ends, hits the
  // full refusal, lists all 64 entries and then empties it again.
  task automatic test_fill_to_capacity();
    write_capacity(cdq_pkg::cap_t'(cdq_pkg::DEPTH));
    for (int i = 0; i < cdq_pkg::DEPTH; i++) begin
      send_request(any_push(), $urandom);
    end
    send_request(any_push(), $urandom);
    send_request(cdq_pkg::KIND_LIST, '0);
    for (int i = 0; i < cdq_pkg::DEPTH; i++) begin
      send_request(any_pop(), $urandom);
    end
    send_request(any_pop(), '0);
    send_request(cdq_pkg::KIND_LIST, '0);
  endtask

  // Random traffic in phases. Each phase has its own capacity, its own
  // balance of pushes against pops, and idling switched on or off. Some
  // phases drift towards full and others towards empty.
  task automatic test_random_traffic();
    int            push_pct;
    int            roll;
    cdq_pkg::cap_t cap;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       cap = cdq_pkg::cap_t'(1);
        1:       cap = cdq_pkg::cap_t'(3);
        2:       cap = cdq_pkg::cap_t'(127);
        3:       cap = cdq_pkg::cap_t'($urandom_range(4, 16));
        4:       cap = cdq_pkg::cap_t'($urandom_range(17, 63));
        default: cap = cdq_pkg::cap_t'(cdq_pkg::DEPTH);
      endcase
      write_capacity(cap);
      sender_idles   = (phase % 3) != 0;
      receiver_idles = (phase % 3) != 1;
      push_pct       = $urandom_range(35, 65);
      for (int i = 0; i < 60; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < push_pct) begin
          send_request(any_push(), $urandom);
        end else if (roll < 92) begin
          send_request(any_pop(), $urandom);
        end else if (roll < 97) begin
          send_request(cdq_pkg::KIND_LIST, $urandom);
        end else begin
          send_request(3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI)), $urandom);
        end
      end
    end
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_basic_operations();
    test_capacity_edges();
    test_result_backpressure();
    test_fill_to_capacity();
    test_random_traffic();

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("circular_deque regression: pass");
    end else begin
      $display("circular_deque regression: fail");
    end
    $finish;
  end

endmodule
